FILE: hdl/pdr_pkg.sv
package pdr_pkg;

    localparam int WORD_W   = 32;
    localparam int LANE_W   = 27;
    localparam int SUM_W    = 30;
    localparam int MAG_W    = 19;
    localparam int RCP_W    = 21;
    localparam int RCP_SH   = 20;
    localparam int SAMPLE_W = 16;

    localparam logic [1:0] REG_INPUT_RATE    = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd2;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S24 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    localparam logic [25:0] FIX_SAT = 26'h2000000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       flt;
        logic [3:0] n;
    } mix_ctrl_t;

    // floor(2^20 / n) for n = 1..8
    function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
        logic [RCP_W-1:0] r;
        case (n)
            4'd1:    r = 21'd1048576;
            4'd2:    r = 21'd524288;
            4'd3:    r = 21'd349525;
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209715;
            4'd6:    r = 21'd174762;
            4'd7:    r = 21'd149796;
            4'd8:    r = 21'd131072;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/pdr_lane.sv
module pdr_lane
    import pdr_pkg::*;
(
    input  logic [WORD_W-1:0]        word,
    input  logic [1:0]               fmt,
    input  logic                     enable,
    output logic signed [LANE_W-1:0] value
);

    logic [7:0]  expo;
    logic [23:0] sig;
    logic [7:0]  rsh;
    logic [25:0] mag;
    logic signed [LANE_W-1:0] fval;
    logic signed [LANE_W-1:0] ival;

    always_comb begin
        expo = word[30:23];
        sig  = {1'b1, word[22:0]};
        rsh  = 8'd126 - expo;
        if (expo == 8'hFF) begin
            mag = (word[22:0] != 23'd0) ? 26'd0 : FIX_SAT;
        end else if (expo == 8'd0) begin
            mag = 26'd0;
        end else if (expo >= 8'd128) begin
            mag = FIX_SAT;
        end else if (expo == 8'd127) begin
            mag = {1'b0, sig, 1'b0};
        end else if (expo == 8'd126) begin
            mag = {2'b00, sig};
        end else if (expo <= 8'd102) begin
            mag = 26'd0;
        end else begin
            mag = {2'b00, sig >> rsh[4:0]};
        end
        fval = word[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb begin
        case (fmt)
            FMT_U8:  ival = LANE_W'($signed({1'b0, word[7:0]}) - $signed(10'sd128));
            FMT_S16: ival = LANE_W'($signed(word[15:0]));
            FMT_S24: ival = LANE_W'($signed(word[23:8]));
            default: ival = '0;
        endcase
    end

    assign value = !enable ? '0 : ((fmt == FMT_F32) ? fval : ival);

endmodule

FILE: hdl/pdr_merge.sv
module pdr_merge
    import pdr_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  mix_ctrl_t                  ctrl,
    input  logic signed [LANE_W-1:0]   lane_val [LANES],
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic [3:0] v_reg;

    logic signed [SUM_W-1:0] sum;
    logic [28:0]             abs_reg;
    logic                    neg1_reg;
    mix_ctrl_t               ctrl1_reg;

    logic [43:0]      prod_scale;
    logic [MAG_W-1:0] m2_reg;
    logic             neg2_reg;
    logic [3:0]       n2_reg;

    logic [MAG_W+RCP_W-1:0] prod_rcp;
    logic [MAG_W-1:0]       q0_reg;
    logic [MAG_W-1:0]       m3_reg;
    logic                   neg3_reg;
    logic [3:0]             n3_reg;

    logic [22:0]              qn;
    logic [22:0]              rem;
    logic [MAG_W:0]           q;
    logic signed [MAG_W+1:0]  sq;
    logic signed [SAMPLE_W-1:0] sample_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < LANES; i++) begin
            sum = sum + SUM_W'(lane_val[i]);
        end
    end

    always_comb begin
        prod_scale = {abs_reg, 15'd0} - {15'd0, abs_reg};
        prod_rcp   = m2_reg * recip(n2_reg);
        qn         = 23'(q0_reg) * 23'(n3_reg);
        rem        = 23'(m3_reg) - qn;
        q          = (rem >= 23'(n3_reg)) ? ({1'b0, q0_reg} + 20'd1) : {1'b0, q0_reg};
        sq         = neg3_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        if (v_reg[0]) begin
            neg1_reg  <= sum < 0;
            abs_reg   <= (sum < 0) ? 29'(-sum) : 29'(sum);
            ctrl1_reg <= ctrl;
        end
        if (v_reg[1]) begin
            m2_reg   <= ctrl1_reg.flt ? prod_scale[42:24] : abs_reg[MAG_W-1:0];
            neg2_reg <= neg1_reg;
            n2_reg   <= ctrl1_reg.n;
        end
        if (v_reg[2]) begin
            q0_reg   <= prod_rcp[RCP_SH+MAG_W-1:RCP_SH];
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            n3_reg   <= n2_reg;
        end
        if (v_reg[3]) begin
            if (sq > 21'sd32767) begin
                sample_reg <= 16'sh7FFF;
            end else if (sq < -21'sd32768) begin
                sample_reg <= -16'sh8000;
            end else begin
                sample_reg <= SAMPLE_W'(sq);
            end
        end
    end

    assign done   = v_reg[3];
    assign sample = sample_reg;

endmodule

FILE: hdl/pdr_phase.sv
module pdr_phase #(
    parameter int OUTPUT_RATE = 16000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        restart,
    input  logic [17:0] rate,
    output logic [1:0]  count
);

    localparam int ACC_W = 20;
    localparam logic [ACC_W-1:0] OUT_R = ACC_W'(OUTPUT_RATE);

    logic [17:0]      phase_acc_reg;
    logic [17:0]      phase_acc_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [ACC_W-1:0] acc0;
    logic [ACC_W-1:0] acc1;
    logic [ACC_W-1:0] acc2;

    always_comb begin
        acc0 = restart ? '0 : ACC_W'(phase_acc_reg);
        acc1 = acc0;
        acc2 = acc0;
        count_next = 2'd0;
        if (acc0 < OUT_R) begin
            acc1 = acc0 + ACC_W'(rate);
            acc2 = acc1;
            count_next = 2'd1;
            if (acc1 < OUT_R) begin
                acc2 = acc1 + ACC_W'(rate);
                count_next = 2'd2;
            end
        end
        phase_acc_next = (acc2 >= OUT_R) ? 18'(acc2 - OUT_R) : 18'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            count_reg     <= '0;
        end else if (step) begin
            phase_acc_reg <= phase_acc_next;
            count_reg     <= count_next;
        end
    end

    assign count = count_reg;

endmodule

FILE: hdl/pcm_downmix_resample_16k_core.sv
// Mono downmix and nearest-neighbor resampler to OUTPUT_RATE. One frame is taken at a time:
// each active channel word is decoded in its own lane (unsigned 8-bit, signed 16-bit, signed
// 24-bit or float32), the lanes are summed, float sums are scaled by 32767, and the magnitude
// is divided by the channel count through a reciprocal multiply with a one-step correction.
// The first result is offered once the frame has passed the five-register datapath (lane
// capture, sum, scale, reciprocal multiply, correction); the second, if any, is offered
// after the first transfers. The next frame is taken in the cycle after its last result
// transfers, as the datapath works on one frame at a time. A frame yields zero, one or
// two copies of its sample; run_last marks the final one. Configuration writes must only
// be made while no frame is in flight.
module pcm_downmix_resample_16k_core
    import pdr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int OUTPUT_RATE  = 16000
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [17:0]                cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_packet_start,
    input  logic [WORD_W-1:0]          s_chan0_word,
    input  logic [WORD_W-1:0]          s_chan1_word,
    input  logic [WORD_W-1:0]          s_chan2_word,
    input  logic [WORD_W-1:0]          s_chan3_word,
    input  logic [WORD_W-1:0]          s_chan4_word,
    input  logic [WORD_W-1:0]          s_chan5_word,
    input  logic [WORD_W-1:0]          s_chan6_word,
    input  logic [WORD_W-1:0]          s_chan7_word,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_mono_sample,
    output logic                       m_run_last
);

    logic [17:0] input_rate_reg;
    logic [3:0]  channel_count_reg;
    logic [1:0]  sample_format_reg;
    logic [3:0]  n_eff;

    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  remain_reg;
    logic [1:0]  remain_next;

    logic        s_xfer;
    logic        m_xfer;
    logic        mix_done;
    logic [1:0]  frame_count;
    mix_ctrl_t   mix_ctrl;

    logic [WORD_W-1:0]        words    [8];
    logic signed [LANE_W-1:0] lane_out [MAX_CHANNELS];
    logic signed [LANE_W-1:0] lane_reg [MAX_CHANNELS];

    assign words[0] = s_chan0_word;
    assign words[1] = s_chan1_word;
    assign words[2] = s_chan2_word;
    assign words[3] = s_chan3_word;
    assign words[4] = s_chan4_word;
    assign words[5] = s_chan5_word;
    assign words[6] = s_chan6_word;
    assign words[7] = s_chan7_word;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    always_comb begin
        if (channel_count_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (channel_count_reg > 4'(MAX_CHANNELS)) begin
            n_eff = 4'(MAX_CHANNELS);
        end else begin
            n_eff = channel_count_reg;
        end
        mix_ctrl.flt = sample_format_reg == FMT_F32;
        mix_ctrl.n   = n_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_rate_reg    <= 18'd48000;
            channel_count_reg <= 4'd2;
            sample_format_reg <= FMT_F32;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INPUT_RATE:    input_rate_reg    <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                REG_SAMPLE_FORMAT: sample_format_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        pdr_lane u_lane (
            .word   (words[i]),
            .fmt    (sample_format_reg),
            .enable (4'(i) < n_eff),
            .value  (lane_out[i])
        );

        always_ff @(posedge aclk) begin
            if (s_xfer) begin
                lane_reg[i] <= lane_out[i];
            end
        end
    end

    pdr_merge #(
        .LANES (MAX_CHANNELS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_xfer),
        .ctrl     (mix_ctrl),
        .lane_val (lane_reg),
        .done     (mix_done),
        .sample   (m_mono_sample)
    );

    pdr_phase #(
        .OUTPUT_RATE (OUTPUT_RATE)
    ) u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_xfer),
        .restart (s_packet_start),
        .rate    (input_rate_reg),
        .count   (frame_count)
    );

    always_comb begin
        state_next  = state_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (mix_done) begin
                    remain_next = frame_count;
                    state_next  = (frame_count == 2'd0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_xfer) begin
                    remain_next = remain_reg - 2'd1;
                    if (remain_reg == 2'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_run_last = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EMIT: begin
                m_valid    = 1'b1;
                m_run_last = remain_reg == 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    a_valid_has_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> remain_reg != 2'd0)
        else $error("result offered with no result left");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done |-> state_reg == ST_CALC)
        else $error("merge finished outside calc state");

    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == ST_CALC)
        else $error("transfer did not start calculation");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && m_run_last |=> state_reg == ST_IDLE)
        else $error("last result did not end the frame");

endmodule

FILE: test/pcm_downmix_resample_16k_core_tb.sv
module pcm_downmix_resample_16k_core_tb
    import pdr_pkg::*;
();

    localparam int MAX_CH        = 8;
    localparam int OUT_RATE      = 16000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1600;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [31:0] F_POS_ONE    = 32'h3F800000;
    localparam logic [31:0] F_NEG_ONE    = 32'hBF800000;
    localparam logic [31:0] F_NAN        = 32'h7FC00001;
    localparam logic [31:0] F_POS_INF    = 32'h7F800000;
    localparam logic [31:0] F_NEG_INF    = 32'hFF800000;
    localparam logic [31:0] F_DENORM     = 32'h00000001;
    localparam logic [31:0] F_NEG_DENORM = 32'h807FFFFF;
    localparam logic [31:0] F_NEG_ZERO   = 32'h80000000;
    localparam logic [31:0] F_TINY       = 32'h33000000;
    localparam logic [31:0] F_SMALL      = 32'h33800000;
    localparam logic [31:0] F_TWO        = 32'h40000000;
    localparam logic [31:0] F_ALMOST_TWO = 32'h3FFFFFFF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } mono_out_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = '0;
    logic [17:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_packet_start = 1'b0;
    logic [31:0] s_chan0_word   = '0;
    logic [31:0] s_chan1_word   = '0;
    logic [31:0] s_chan2_word   = '0;
    logic [31:0] s_chan3_word   = '0;
    logic [31:0] s_chan4_word   = '0;
    logic [31:0] s_chan5_word   = '0;
    logic [31:0] s_chan6_word   = '0;
    logic [31:0] s_chan7_word   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic signed [15:0] m_mono_sample;
    logic        m_run_last;

    // shadow of the block's registers and phase state
    logic [17:0] src_rate    = 18'd48000;
    logic [3:0]  chan_cfg    = 4'd2;
    logic [1:0]  fmt_cfg     = FMT_F32;
    logic [17:0] phase_model = '0;

    mono_out_t expected_samples[$];
    int        fail_count  = 0;
    int        cycle_count = 0;

    logic hold_request = 1'b0;
    int   hold_left    = 0;
    int   rx_mode      = 0;
    int   rx_span      = 0;
    int   rx_tick      = 0;

    pcm_downmix_resample_16k_core #(
        .MAX_CHANNELS(MAX_CH),
        .OUTPUT_RATE (OUT_RATE)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_start(s_packet_start),
        .s_chan0_word  (s_chan0_word),
        .s_chan1_word  (s_chan1_word),
        .s_chan2_word  (s_chan2_word),
        .s_chan3_word  (s_chan3_word),
        .s_chan4_word  (s_chan4_word),
        .s_chan5_word  (s_chan5_word),
        .s_chan6_word  (s_chan6_word),
        .s_chan7_word  (s_chan7_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mono_sample (m_mono_sample),
        .m_run_last    (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // float32 to signed Q.24, saturated at +/-2
    function automatic longint flt_to_fix(input logic [31:0] x);
        logic [7:0]  ex;
        logic [31:0] sig;
        longint      mag;
        ex  = x[30:23];
        sig = {8'd0, 1'b1, x[22:0]};
        if (ex == 8'hFF) begin
            mag = (x[22:0] != 0) ? 0 : FIX_SAT;
        end else if (ex == 0) begin
            mag = 0;
        end else if (ex >= 128) begin
            mag = FIX_SAT;
        end else if (ex >= 126) begin
            mag = sig << (ex - 126);
        end else if (126 - ex >= 24) begin
            mag = 0;
        end else begin
            mag = sig >> (126 - ex);
        end
        return x[31] ? -mag : mag;
    endfunction

    function automatic int decode_word(input logic [31:0] x, input logic [1:0] fmt);
        int                 v;
        logic signed [15:0] h;
        case (fmt)
            FMT_U8: begin
                v = x[7:0];
                v = v - 128;
            end
            FMT_S16: begin
                h = x[15:0];
                v = h;
            end
            default: begin
                h = x[23:8];
                v = h;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] mix_frame(input logic [7:0][31:0] w);
        int     n;
        int     i;
        int     isum;
        longint fsum;
        longint q;
        n = chan_cfg;
        if (n == 0) n = 1;
        if (n > MAX_CH) n = MAX_CH;
        isum = 0;
        fsum = 0;
        if (fmt_cfg == FMT_F32) begin
            for (i = 0; i < n; i++) fsum += flt_to_fix(w[i]);
            q = (fsum * 32767) / (n * 16777216);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[15:0];
        end
        for (i = 0; i < n; i++) isum += decode_word(w[i], fmt_cfg);
        isum = isum / n;
        return isum[15:0];
    endfunction

    task automatic predict_frame();
        logic [7:0][31:0]   w;
        logic signed [15:0] smp;
        logic [31:0]        acc;
        int                 cnt;
        int                 k;
        mono_out_t          item;
        w = {s_chan7_word, s_chan6_word, s_chan5_word, s_chan4_word,
             s_chan3_word, s_chan2_word, s_chan1_word, s_chan0_word};
        if (s_packet_start) phase_model = '0;
        smp = mix_frame(w);
        acc = phase_model;
        cnt = 0;
        while (cnt < 2 && acc < OUT_RATE) begin
            acc += src_rate;
            cnt++;
        end
        if (acc >= OUT_RATE) acc -= OUT_RATE;
        else acc = 0;
        phase_model = acc[17:0];
        for (k = 0; k < cnt; k++) begin
            item.sample = smp;
            item.last   = (k == cnt - 1);
            expected_samples = {expected_samples, item};
        end
    endtask

    task automatic check_sample();
        mono_out_t e;
        if (expected_samples.size() == 0) begin
            $error("unexpected transfer: mono_sample %0d run_last %0b", m_mono_sample, m_run_last);
            fail_count++;
        end else begin
            e = expected_samples.pop_front();
            if (m_mono_sample !== e.sample) begin
                $error("mono_sample: expected %0d, actual %0d", e.sample, m_mono_sample);
                fail_count++;
            end
            if (m_run_last !== e.last) begin
                $error("run_last: expected %0b, actual %0b", e.last, m_run_last);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_frame();
            if (m_valid && m_ready) check_sample();
        end
    end

    // receiver: long hold-off on request, otherwise stretches of random stall patterns
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(5, 80);
            end
            rx_span--;
            rx_tick++;
            case (rx_mode)
                0:       m_ready = 1'b1;
                1:       m_ready = 1'($urandom_range(0, 1));
                2:       m_ready = (rx_tick % 4) == 0;
                default: m_ready = $urandom_range(0, 9) < 8;
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("pcm_downmix_resample_16k_core_tb: FAIL");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            REG_INPUT_RATE:    src_rate = val;
            REG_CHANNEL_COUNT: chan_cfg = val[3:0];
            REG_SAMPLE_FORMAT: fmt_cfg  = val[1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_frame(input logic ps, input logic [7:0][31:0] w);
        @(negedge aclk);
        s_valid        = 1'b1;
        s_packet_start = ps;
        s_chan0_word   = w[0];
        s_chan1_word   = w[1];
        s_chan2_word   = w[2];
        s_chan3_word   = w[3];
        s_chan4_word   = w[4];
        s_chan5_word   = w[5];
        s_chan6_word   = w[6];
        s_chan7_word   = w[7];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender(input int n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // all results in, then let a frame with no output finish too
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word(input logic [1:0] fmt);
        logic [31:0] r;
        r = $urandom;
        if (fmt == FMT_F32) begin
            case ($urandom_range(0, 7))
                0: ;
                1: begin
                    r[30:23] = 8'hFF;
                    if (r[22:0] == 0) r[0] = 1'b1;
                end
                2: r[30:0] = {8'hFF, 23'd0};
                3: r[30:23] = 8'h00;
                default: r[30:23] = 8'($urandom_range(100, 130));
            endcase
        end else begin
            case ($urandom_range(0, 7))
                0: r = '0;
                1: r = '1;
                2: r = r | 32'h00808080;
                3: r = r & 32'hFF7F7F7F;
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0][31:0] rand_frame(input logic [1:0] fmt);
        logic [7:0][31:0] w;
        int               i;
        for (i = 0; i < 8; i++) w[i] = rand_word(fmt);
        return w;
    endfunction

    function automatic logic [17:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return 18'd0;
            1:       return 18'h3FFFF;
            2:       return 18'd8000;
            3:       return 18'd192000;
            4:       return 18'd16000;
            5:       return 18'($urandom_range(0, 262143));
            default: return 18'($urandom_range(8000, 192000));
        endcase
    endfunction

    task automatic test_default_config();
        send_frame(1'b1, {8{F_POS_ONE}});
        send_frame(1'b0, {{6{F_POS_ONE}}, F_POS_ONE, F_NEG_ONE});
        wait_drained();
    endtask

    task automatic test_float_specials();
        write_reg(REG_CHANNEL_COUNT, 18'd8);
        write_reg(REG_INPUT_RATE, 18'd16000);
        send_frame(1'b1, {8{F_NAN}});
        send_frame(1'b0, {8{F_POS_INF}});
        send_frame(1'b0, {8{F_NEG_INF}});
        send_frame(1'b0, {F_NEG_ONE, F_ALMOST_TWO, F_TWO, F_SMALL,
                          F_TINY, F_NEG_ZERO, F_NEG_DENORM, F_DENORM});
        send_frame(1'b0, {8{F_ALMOST_TWO}});
        wait_drained();
    endtask

    task automatic test_int_formats();
        write_reg(REG_CHANNEL_COUNT, 18'd3);
        write_reg(REG_SAMPLE_FORMAT, FMT_U8);
        send_frame(1'b1, {8{32'h00000000}});
        send_frame(1'b0, {8{32'hFFFFFFFF}});
        wait_drained();
        write_reg(REG_SAMPLE_FORMAT, FMT_S16);
        send_frame(1'b0, {8{32'hFFFF8000}});
        // -2/3 truncates toward zero
        send_frame(1'b0, {{5{32'h12345678}}, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF});
        wait_drained();
        write_reg(REG_SAMPLE_FORMAT, FMT_S24);
        send_frame(1'b0, {8{32'h00800000}});
        send_frame(1'b0, {8{32'hFF7FFFFF}});
        send_frame(1'b0, {8{32'h00FFFF00}});
        wait_drained();
    endtask

    task automatic test_channel_count_limits();
        logic [7:0][31:0] w;
        w    = {8{32'h00007FFF}};
        w[0] = 32'd100;
        write_reg(REG_SAMPLE_FORMAT, FMT_S16);
        write_reg(REG_CHANNEL_COUNT, 18'd0);
        send_frame(1'b1, w);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 18'd9);
        send_frame(1'b0, w);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 18'd15);
        send_frame(1'b0, w);
        wait_drained();
        // out-of-range index leaves every register alone
        write_reg(REG_UNUSED, 18'd0);
        send_frame(1'b0, w);
        wait_drained();
    endtask

    task automatic test_rate_extremes();
        logic [7:0][31:0] w;
        w    = {8{32'hFFFFFFFF}};
        w[0] = 32'h000000AB;
        write_reg(REG_SAMPLE_FORMAT, FMT_U8);
        write_reg(REG_CHANNEL_COUNT, 18'd1);
        write_reg(REG_INPUT_RATE, 18'd0);
        send_frame(1'b1, w);
        wait_drained();
        write_reg(REG_INPUT_RATE, 18'd4000);
        send_frame(1'b1, w);
        wait_drained();
        write_reg(REG_INPUT_RATE, 18'h3FFFF);
        send_frame(1'b1, w);
        send_frame(1'b0, w);
        wait_drained();
        write_reg(REG_INPUT_RATE, 18'd8000);
        send_frame(1'b1, w);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        int i;
        write_reg(REG_INPUT_RATE, 18'd8000);
        write_reg(REG_CHANNEL_COUNT, 18'd8);
        write_reg(REG_SAMPLE_FORMAT, FMT_S24);
        @(posedge aclk);
        hold_request = 1'b1;
        for (i = 0; i < 24; i++) send_frame(i == 0, rand_frame(fmt_cfg));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          phase_left;
        int          burst_left;
        int          gap_max;
        logic [17:0] val;
        logic        ps;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            if ($urandom_range(0, 3) != 0) write_reg(REG_INPUT_RATE, pick_rate());
            if ($urandom_range(0, 2) != 0) begin
                val = 18'($urandom);
                val[3:0] = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                          : $urandom_range(0, 15));
                write_reg(REG_CHANNEL_COUNT, val);
            end
            if ($urandom_range(0, 2) != 0) write_reg(REG_SAMPLE_FORMAT, 18'($urandom));
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 18'($urandom));
            phase_left = $urandom_range(20, 80);
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 24);
            burst_left = $urandom_range(1, 40);
            while (phase_left > 0 && sent < RANDOM_ITEMS) begin
                if (gap_max != 0 && burst_left <= 0) begin
                    idle_sender($urandom_range(1, gap_max));
                    burst_left = $urandom_range(1, 40);
                end
                ps = (phase_left == 1 || $urandom_range(0, 15) == 0);
                send_frame(ps, rand_frame(fmt_cfg));
                burst_left--;
                phase_left--;
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_default_config();
        test_float_specials();
        test_int_formats();
        test_channel_count_limits();
        test_rate_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        if (fail_count == 0) begin
            $display("pcm_downmix_resample_16k_core_tb: PASS");
        end else begin
            $display("pcm_downmix_resample_16k_core_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: pcm_downmix_resample_16k_core.f
hdl/pdr_pkg.sv
hdl/pdr_lane.sv
hdl/pdr_merge.sv
hdl/pdr_phase.sv
hdl/pcm_downmix_resample_16k_core.sv
test/pcm_downmix_resample_16k_core_tb.sv
